// ===== rtl/okl_pkg.sv =====
package okl_pkg;

  localparam int ACTION_W = 3;
  localparam int KEY_W    = 32;
  localparam int COORD_W  = 16;
  localparam int HANDLE_W = 32;
  localparam int POS_W    = 4;
  localparam int STATUS_W = 2;
  localparam int COUNT_W  = 5;
  localparam int LIMIT_W  = 5;

  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 5'd16;

  typedef enum logic [ACTION_W-1:0] {
    ACT_PUSH       = 3'd0,
    ACT_REMOVE_KEY = 3'd1,
    ACT_REMOVE_POS = 3'd2,
    ACT_FIND       = 3'd3,
    ACT_READ       = 3'd4,
    ACT_CLEAR      = 3'd5
  } action_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK   = 2'd0,
    ST_MISS = 2'd1,
    ST_FULL = 2'd2
  } status_t;

  typedef enum logic [0:0] {
    S_IDLE  = 1'b0,
    S_APPLY = 1'b1
  } state_t;

  typedef struct packed {
    logic        [KEY_W-1:0]    key;
    logic signed [COORD_W-1:0]  x;
    logic signed [COORD_W-1:0]  y;
    logic        [HANDLE_W-1:0] handle;
  } entry_t;

  typedef struct packed {
    logic load;
    logic shift;
  } cell_ctrl_t;

endpackage

// ===== rtl/okl_if.sv =====
interface okl_req_if;
  import okl_pkg::*;

  logic                       valid;
  logic                       ready;
  logic        [ACTION_W-1:0] action;
  logic        [KEY_W-1:0]    key;
  logic signed [COORD_W-1:0]  coord_x;
  logic signed [COORD_W-1:0]  coord_y;
  logic        [HANDLE_W-1:0] handle;
  logic        [POS_W-1:0]    position;

  modport source (output valid, action, key, coord_x, coord_y, handle, position,
                  input ready);
  modport sink (input valid, action, key, coord_x, coord_y, handle, position,
                output ready);
endinterface

interface okl_rsp_if;
  import okl_pkg::*;

  logic                       valid;
  logic                       ready;
  logic        [STATUS_W-1:0] status;
  logic        [POS_W-1:0]    found_position;
  logic        [KEY_W-1:0]    entry_key;
  logic signed [COORD_W-1:0]  entry_x;
  logic signed [COORD_W-1:0]  entry_y;
  logic        [HANDLE_W-1:0] entry_handle;
  logic        [COUNT_W-1:0]  entry_count;

  modport source (output valid, status, found_position, entry_key, entry_x, entry_y,
                  entry_handle, entry_count, input ready);
  modport sink (input valid, status, found_position, entry_key, entry_x, entry_y,
                entry_handle, entry_count, output ready);
endinterface

interface okl_cfg_if;
  import okl_pkg::*;

  logic               valid;
  logic               ready;
  logic [LIMIT_W-1:0] data;

  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface

// ===== rtl/okl_cell.sv =====
module okl_cell
  import okl_pkg::*;
(
  input  logic             clk,
  input  cell_ctrl_t       ctrl,
  input  entry_t           new_entry,
  input  entry_t           next_entry,
  input  logic [KEY_W-1:0] search_key,
  output entry_t           entry,
  output logic             match
);

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      entry <= new_entry;
    end else if (ctrl.shift) begin
      entry <= next_entry;
    end
  end

  assign match = (entry.key == search_key);

endmodule

// ===== rtl/ordered_keyed_slot_list.sv =====
// Ordered list of up to CAPACITY keyed entries held in a row of cells, one entry per
// cell. When an item is accepted each cell compares its key with the item's key and the
// match vector is registered; then, once the output register is free or being taken, the
// position is encoded, the cells behind a removed entry take their neighbour's contents
// in one shift and the result is loaded into the output register. A new item is accepted
// while the previous result still waits there, but not before the previous item has been
// applied. The limit register may be written at any time the list is idle; lowering it
// truncates the entry count at once.
module ordered_keyed_slot_list
  import okl_pkg::*;
#(
  parameter int CAPACITY = 16
) (
  input  logic      clk,
  input  logic      rst,
  okl_req_if.sink   req,
  okl_rsp_if.source rsp,
  okl_cfg_if.sink   cfg
);

  localparam int CW   = $clog2(CAPACITY + 1);
  localparam int IW   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int LW   = (CW > LIMIT_W) ? CW : LIMIT_W;
  localparam int PW   = (IW > POS_W) ? IW : POS_W;
  localparam int CMPW = (CW > POS_W) ? CW : POS_W;
  localparam int RD_N = (CAPACITY < (1 << POS_W)) ? CAPACITY : (1 << POS_W);

  state_t state;
  state_t state_next;

  logic [CW-1:0]      live_count;
  logic [CW-1:0]      count_next;
  logic [LIMIT_W-1:0] limit;
  logic [LW-1:0]      eff_limit;
  logic [LW-1:0]      cfg_eff;

  logic [ACTION_W-1:0] action_q;
  entry_t              new_q;
  logic [POS_W-1:0]    pos_q;
  logic [CAPACITY-1:0] match_q;

  entry_t              cell_q     [CAPACITY];
  cell_ctrl_t          cell_ctrl  [CAPACITY];
  logic [CAPACITY-1:0] cell_match;
  logic [CAPACITY-1:0] match_d;

  logic          fire;
  logic          accept;
  logic          matched;
  logic [IW-1:0] match_pos;
  logic          in_range;
  entry_t        rd_entry;

  logic          drop_en;
  logic [PW-1:0] drop_pos;
  logic          load_en;
  logic [CW-1:0] load_idx;
  logic [CW-1:0] count_drop;

  logic [STATUS_W-1:0] status_d;
  logic [POS_W-1:0]    fpos_d;
  entry_t              entry_d;

  logic                out_valid;
  logic [STATUS_W-1:0] out_status;
  logic [POS_W-1:0]    out_fpos;
  entry_t              out_entry;
  logic [COUNT_W-1:0]  out_count;

  entry_t req_entry;

  assign req_entry = '{key: req.key, x: req.coord_x, y: req.coord_y, handle: req.handle};

  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    entry_t next_entry;

    if (g == CAPACITY - 1) begin : g_tail
      assign next_entry = cell_q[g];
    end else begin : g_body
      assign next_entry = cell_q[g+1];
    end

    assign cell_ctrl[g].load  = fire && load_en && (load_idx == CW'(g));
    assign cell_ctrl[g].shift = fire && drop_en && (PW'(g) >= drop_pos);
    assign match_d[g]         = cell_match[g] && (CW'(g) < live_count);

    okl_cell u_cell (
      .clk        (clk),
      .ctrl       (cell_ctrl[g]),
      .new_entry  (new_q),
      .next_entry (next_entry),
      .search_key (req.key),
      .entry      (cell_q[g]),
      .match      (cell_match[g])
    );
  end

  always_comb begin
    state_next = state;
    req.ready  = 1'b0;
    fire       = 1'b0;
    unique case (state)
      S_IDLE: begin
        req.ready = 1'b1;
        if (req.valid) begin
          state_next = S_APPLY;
        end
      end
      S_APPLY: begin
        if (!out_valid || rsp.ready) begin
          fire       = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  assign accept = req.valid && req.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      action_q <= req.action;
      new_q    <= req_entry;
      pos_q    <= req.position;
      match_q  <= match_d;
    end
  end

  always_comb begin
    match_pos = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      match_pos = match_pos | (match_q[i] ? IW'(i) : IW'(0));
    end
    rd_entry = '0;
    for (int i = 0; i < RD_N; i++) begin
      if (pos_q == POS_W'(i)) begin
        rd_entry = cell_q[i];
      end
    end
  end

  assign matched   = |match_q;
  assign in_range  = (CMPW'(pos_q) < CMPW'(live_count));
  assign eff_limit = (LW'(limit) > LW'(CAPACITY)) ? LW'(CAPACITY) : LW'(limit);
  assign cfg_eff   = (LW'(cfg.data) > LW'(CAPACITY)) ? LW'(CAPACITY) : LW'(cfg.data);
  assign count_drop = matched ? live_count - CW'(1) : live_count;

  always_comb begin
    drop_en    = 1'b0;
    drop_pos   = PW'(match_pos);
    load_en    = 1'b0;
    load_idx   = count_drop;
    count_next = live_count;
    status_d   = ST_OK;
    fpos_d     = '0;
    entry_d    = '0;
    unique case (action_q)
      ACT_PUSH: begin
        drop_en = matched;
        if (LW'(count_drop) >= eff_limit) begin
          status_d   = ST_FULL;
          count_next = count_drop;
        end else begin
          load_en    = 1'b1;
          count_next = count_drop + CW'(1);
        end
      end
      ACT_REMOVE_KEY: begin
        if (matched) begin
          drop_en    = 1'b1;
          count_next = count_drop;
        end else begin
          status_d = ST_MISS;
        end
      end
      ACT_REMOVE_POS: begin
        drop_pos = PW'(pos_q);
        if (in_range) begin
          drop_en    = 1'b1;
          count_next = live_count - CW'(1);
        end else begin
          status_d = ST_MISS;
        end
      end
      ACT_FIND: begin
        if (matched) begin
          fpos_d = POS_W'(match_pos);
        end else begin
          status_d = ST_MISS;
        end
      end
      ACT_READ: begin
        if (in_range) begin
          entry_d = rd_entry;
        end else begin
          status_d = ST_MISS;
        end
      end
      ACT_CLEAR: begin
        count_next = '0;
      end
      default: begin
        status_d = ST_MISS;
      end
    endcase
  end

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      live_count <= '0;
      limit      <= LIMIT_RESET;
    end else begin
      if (fire) begin
        live_count <= count_next;
      end
      if (cfg.valid) begin
        limit <= cfg.data;
        if (LW'(live_count) > cfg_eff) begin
          live_count <= CW'(cfg_eff);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (fire) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_status <= status_d;
      out_fpos   <= fpos_d;
      out_entry  <= entry_d;
      out_count  <= COUNT_W'(count_next);
    end
  end

  assign rsp.valid          = out_valid;
  assign rsp.status         = out_status;
  assign rsp.found_position = out_fpos;
  assign rsp.entry_key      = out_entry.key;
  assign rsp.entry_x        = out_entry.x;
  assign rsp.entry_y        = out_entry.y;
  assign rsp.entry_handle   = out_entry.handle;
  assign rsp.entry_count    = out_count;

endmodule

// ===== rtl/okl_checker.sv =====
module okl_checker
  import okl_pkg::*;
(
  input logic                clk,
  input logic                rst,
  input logic                req_valid,
  input logic                req_ready,
  input logic                rsp_valid,
  input logic                rsp_ready,
  input logic [STATUS_W-1:0] rsp_status,
  input logic [POS_W-1:0]    rsp_found_position,
  input logic [KEY_W-1:0]    rsp_entry_key,
  input logic [HANDLE_W-1:0] rsp_entry_handle
);

  // A stalled result keeps its place and its contents.
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status)
      && $stable(rsp_entry_key))
    else $error("result changed while stalled");

  // Only one item at a time is held for applying; a result may still wait in the output register.
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |=> !req_ready)
    else $error("item accepted in consecutive cycles");

  a_status_code: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> (rsp_status == ST_OK) || (rsp_status == ST_MISS)
      || (rsp_status == ST_FULL))
    else $error("status code out of range");

  // A failed action reports no position and no entry.
  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (rsp_status != ST_OK) |-> (rsp_found_position == '0)
      && (rsp_entry_key == '0) && (rsp_entry_handle == '0))
    else $error("failed action reports data");

endmodule

bind ordered_keyed_slot_list okl_checker u_okl_checker (
  .clk                (clk),
  .rst                (rst),
  .req_valid          (req.valid),
  .req_ready          (req.ready),
  .rsp_valid          (rsp.valid),
  .rsp_ready          (rsp.ready),
  .rsp_status         (rsp.status),
  .rsp_found_position (rsp.found_position),
  .rsp_entry_key      (rsp.entry_key),
  .rsp_entry_handle   (rsp.entry_handle)
);

// ===== tb/ordered_keyed_slot_list_checker.sv =====
`timescale 1ns / 1ps

module ordered_keyed_slot_list_checker
  import okl_pkg::*;
#(
  parameter int CAPACITY = 16
) (
  input  logic clk,
  input  logic rst,
  okl_req_if   req,
  okl_rsp_if   rsp,
  okl_cfg_if   cfg,
  output int   mismatch_count,
  output int   results_owed
);

  typedef struct {
    status_t            status;
    logic [POS_W-1:0]   found_position;
    entry_t             entry;
    logic [COUNT_W-1:0] count;
  } outcome_t;

  entry_t             slots [CAPACITY];
  int                 slot_count;
  logic [LIMIT_W-1:0] limit_reg;
  outcome_t           owed [$];

  function automatic int effective_limit();
    return (int'(limit_reg) > CAPACITY) ? CAPACITY : int'(limit_reg);
  endfunction

  function automatic int find_slot(logic [KEY_W-1:0] key);
    for (int i = 0; i < slot_count; i++) begin
      if (slots[i].key == key) begin
        return i;
      end
    end
    return -1;
  endfunction

  function automatic void remove_slot(int pos);
    for (int i = pos; i + 1 < slot_count; i++) begin
      slots[i] = slots[i + 1];
    end
    slot_count--;
  endfunction

  function automatic outcome_t predict_outcome(logic [ACTION_W-1:0] action,
                                               logic [KEY_W-1:0] key,
                                               logic signed [COORD_W-1:0] x,
                                               logic signed [COORD_W-1:0] y,
                                               logic [HANDLE_W-1:0] handle,
                                               logic [POS_W-1:0] position);
    outcome_t result;
    int       slot;
    result.status         = ST_OK;
    result.found_position = '0;
    result.entry          = '0;
    slot = find_slot(key);
    case (action)
      ACT_PUSH: begin
        if (slot >= 0) begin
          remove_slot(slot);
        end
        if (slot_count >= effective_limit()) begin
          result.status = ST_FULL;
        end else begin
          slots[slot_count] = '{key: key, x: x, y: y, handle: handle};
          slot_count++;
        end
      end
      ACT_REMOVE_KEY: begin
        if (slot >= 0) begin
          remove_slot(slot);
        end else begin
          result.status = ST_MISS;
        end
      end
      ACT_REMOVE_POS: begin
        if (int'(position) < slot_count) begin
          remove_slot(int'(position));
        end else begin
          result.status = ST_MISS;
        end
      end
      ACT_FIND: begin
        if (slot >= 0) begin
          result.found_position = slot[POS_W-1:0];
        end else begin
          result.status = ST_MISS;
        end
      end
      ACT_READ: begin
        if (int'(position) < slot_count) begin
          result.entry = slots[position];
        end else begin
          result.status = ST_MISS;
        end
      end
      ACT_CLEAR: begin
        slot_count = 0;
      end
      default: begin
        result.status = ST_MISS;
      end
    endcase
    result.count = slot_count[COUNT_W-1:0];
    return result;
  endfunction

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $error("%s mismatch: expected %0h, actual %0h", name, want, got);
      mismatch_count++;
    end
  endfunction

  always @(posedge clk) begin
    outcome_t want;
    if (rst) begin
      slot_count     = 0;
      limit_reg      = LIMIT_RESET;
      mismatch_count = 0;
      owed.delete();
    end else begin
      if (rsp.valid && rsp.ready) begin
        if (owed.size() == 0) begin
          $error("Result item arrived with no item outstanding");
          mismatch_count++;
        end else begin
          want = owed.pop_front();
          check_field("status", want.status, rsp.status);
          check_field("found_position", want.found_position, rsp.found_position);
          check_field("entry_key", want.entry.key, rsp.entry_key);
          check_field("entry_x", want.entry.x, rsp.entry_x);
          check_field("entry_y", want.entry.y, rsp.entry_y);
          check_field("entry_handle", want.entry.handle, rsp.entry_handle);
          check_field("entry_count", want.count, rsp.entry_count);
        end
      end
      if (cfg.valid && cfg.ready) begin
        limit_reg = cfg.data;
        if (slot_count > effective_limit()) begin
          slot_count = effective_limit();
        end
      end
      if (req.valid && req.ready) begin
        owed.push_back(predict_outcome(req.action, req.key, req.coord_x, req.coord_y,
                                       req.handle, req.position));
      end
    end
    results_owed <= owed.size();
  end

endmodule

// ===== tb/ordered_keyed_slot_list_tb.sv =====
`timescale 1ns / 1ps

module ordered_keyed_slot_list_tb;
  import okl_pkg::*;

  localparam int CAPACITY       = 16;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int PHASE_ITEMS    = 110;
  localparam int PHASES         = 10;
  localparam int KEY_POOL       = 20;

  localparam logic [ACTION_W-1:0] ACT_SPARE_LO = 3'd6;
  localparam logic [ACTION_W-1:0] ACT_SPARE_HI = 3'd7;

  logic             clk         = 1'b0;
  logic             rst;
  logic             calm        = 1'b0;
  int               idle_cycles = 0;
  int               rsp_hold    = 0;
  int               mismatch_count;
  int               results_owed;
  logic [KEY_W-1:0] key_pool [KEY_POOL];
  int               phase_limits [PHASES] = '{16, 9, 16, 3, 0, 1, 16, 0, 15, 16};

  okl_req_if req_ch ();
  okl_rsp_if rsp_ch ();
  okl_cfg_if cfg_ch ();

  ordered_keyed_slot_list #(
    .CAPACITY(CAPACITY)
  ) dut (
    .clk(clk),
    .rst(rst),
    .req(req_ch),
    .rsp(rsp_ch),
    .cfg(cfg_ch)
  );

  ordered_keyed_slot_list_checker #(
    .CAPACITY(CAPACITY)
  ) checker_inst (
    .clk(clk),
    .rst(rst),
    .req(req_ch),
    .rsp(rsp_ch),
    .cfg(cfg_ch),
    .mismatch_count(mismatch_count),
    .results_owed(results_owed)
  );

  always #6 clk = ~clk;

  always @(posedge clk) begin
    if (rst) begin
      rsp_ch.ready <= 1'b0;
      rsp_hold     <= 0;
    end else if (calm) begin
      rsp_ch.ready <= 1'b1;
      rsp_hold     <= 0;
    end else if (rsp_hold > 1) begin
      rsp_hold <= rsp_hold - 1;
    end else if ($urandom_range(0, 99) < 12) begin
      rsp_ch.ready <= 1'b0;
      rsp_hold     <= $urandom_range(1, 10);
    end else begin
      rsp_ch.ready <= 1'b1;
      rsp_hold     <= 0;
    end
  end

  always @(posedge clk) begin
    if (rst || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles == WATCHDOG_LIMIT) begin
      $display("FAIL ordered_keyed_slot_list");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic send_request(input logic [ACTION_W-1:0] action,
                              input logic [KEY_W-1:0] key,
                              input logic signed [COORD_W-1:0] x,
                              input logic signed [COORD_W-1:0] y,
                              input logic [HANDLE_W-1:0] handle,
                              input logic [POS_W-1:0] position);
    if (!calm && $urandom_range(0, 99) < 20) begin
      req_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
    req_ch.valid    <= 1'b1;
    req_ch.action   <= action;
    req_ch.key      <= key;
    req_ch.coord_x  <= x;
    req_ch.coord_y  <= y;
    req_ch.handle   <= handle;
    req_ch.position <= position;
    do @(posedge clk); while (!req_ch.ready);
  endtask

  task automatic send_random_request();
    int                  pick;
    logic [ACTION_W-1:0] action;
    logic [KEY_W-1:0]    key;
    pick = $urandom_range(0, 99);
    if (pick < 40) begin
      action = ACT_PUSH;
    end else if (pick < 52) begin
      action = ACT_REMOVE_KEY;
    end else if (pick < 62) begin
      action = ACT_REMOVE_POS;
    end else if (pick < 76) begin
      action = ACT_FIND;
    end else if (pick < 92) begin
      action = ACT_READ;
    end else if (pick < 95) begin
      action = ACT_CLEAR;
    end else if (pick < 98) begin
      action = ACT_SPARE_LO;
    end else begin
      action = ACT_SPARE_HI;
    end
    if ($urandom_range(0, 3) != 0) begin
      key = key_pool[$urandom_range(0, KEY_POOL - 1)];
    end else begin
      key = $urandom();
    end
    send_request(action, key, COORD_W'($urandom()), COORD_W'($urandom()), $urandom(),
                 POS_W'($urandom_range(0, 15)));
  endtask

  task automatic wait_for_results();
    req_ch.valid <= 1'b0;
    @(posedge clk);
    while (results_owed != 0) @(posedge clk);
  endtask

  task automatic write_limit(input logic [LIMIT_W-1:0] value);
    cfg_ch.valid <= 1'b1;
    cfg_ch.data  <= value;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
  endtask

  initial begin
    rst             <= 1'b1;
    req_ch.valid    <= 1'b0;
    req_ch.action   <= ACT_PUSH;
    req_ch.key      <= '0;
    req_ch.coord_x  <= '0;
    req_ch.coord_y  <= '0;
    req_ch.handle   <= '0;
    req_ch.position <= '0;
    cfg_ch.valid    <= 1'b0;
    cfg_ch.data     <= LIMIT_RESET;
    foreach (key_pool[i]) begin
      key_pool[i] = $urandom();
    end
    key_pool[0] = '0;
    key_pool[1] = '1;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    write_limit(5'd16);
    send_request(ACT_READ, 32'h0, 16'sh0, 16'sh0, 32'h0, 4'd0);
    send_request(ACT_FIND, 32'h0, 16'sh0, 16'sh0, 32'h0, 4'd0);
    send_request(ACT_REMOVE_KEY, 32'h0, 16'sh0, 16'sh0, 32'h0, 4'd0);
    send_request(ACT_REMOVE_POS, 32'h0, 16'sh0, 16'sh0, 32'h0, 4'd0);
    send_request(ACT_PUSH, 32'h0, 16'sh8000, 16'sh7FFF, 32'h0, 4'd15);
    send_request(ACT_PUSH, 32'hFFFF_FFFF, 16'sh7FFF, 16'sh8000, 32'hFFFF_FFFF, 4'd0);
    send_request(ACT_PUSH, 32'h1234_5678, 16'shFFFF, 16'sh0, 32'hA5A5_5A5A, 4'd7);
    send_request(ACT_FIND, 32'hFFFF_FFFF, 16'sh0, 16'sh0, 32'h0, 4'd0);
    send_request(ACT_PUSH, 32'h0, 16'sh1, 16'shFFFF, 32'h5A5A_A5A5, 4'd0);
    send_request(ACT_READ, 32'h0, 16'sh0, 16'sh0, 32'h0, 4'd2);
    send_request(ACT_READ, 32'h0, 16'sh0, 16'sh0, 32'h0, 4'd0);
    send_request(ACT_READ, 32'h0, 16'sh0, 16'sh0, 32'h0, 4'd15);
    send_request(ACT_REMOVE_POS, 32'h0, 16'sh0, 16'sh0, 32'h0, 4'd0);
    send_request(ACT_REMOVE_KEY, 32'h0, 16'sh0, 16'sh0, 32'h0, 4'd0);
    send_request(ACT_SPARE_LO, 32'h1234_5678, 16'sh0, 16'sh0, 32'h0, 4'd0);
    send_request(ACT_SPARE_HI, 32'h1234_5678, 16'sh0, 16'sh0, 32'h0, 4'd0);
    send_request(ACT_CLEAR, 32'h0, 16'sh0, 16'sh0, 32'h0, 4'd0);

    wait_for_results();
    write_limit(5'd2);
    send_request(ACT_PUSH, 32'h11, 16'sh11, 16'sh11, 32'h11, 4'd0);
    send_request(ACT_PUSH, 32'h22, 16'sh22, 16'sh22, 32'h22, 4'd0);
    send_request(ACT_PUSH, 32'h33, 16'sh33, 16'sh33, 32'h33, 4'd0);
    send_request(ACT_PUSH, 32'h11, 16'sh44, 16'sh44, 32'h44, 4'd0);
    send_request(ACT_FIND, 32'h33, 16'sh0, 16'sh0, 32'h0, 4'd0);

    wait_for_results();
    write_limit(5'd1);
    send_request(ACT_READ, 32'h0, 16'sh0, 16'sh0, 32'h0, 4'd1);
    send_request(ACT_READ, 32'h0, 16'sh0, 16'sh0, 32'h0, 4'd0);

    wait_for_results();
    write_limit(5'd0);
    send_request(ACT_PUSH, 32'h55, 16'sh55, 16'sh55, 32'h55, 4'd0);

    phase_limits[7] = $urandom_range(0, 16);
    for (int p = 0; p < PHASES; p++) begin
      wait_for_results();
      write_limit(phase_limits[p][LIMIT_W-1:0]);
      if (p == PHASES - 1) begin
        calm <= 1'b1;
      end
      repeat (PHASE_ITEMS) send_random_request();
    end

    wait_for_results();
    repeat (8) @(posedge clk);
    if (mismatch_count == 0 && results_owed == 0) begin
      $display("PASS ordered_keyed_slot_list");
    end else begin
      $display("FAIL ordered_keyed_slot_list");
    end
    $finish;
  end

endmodule
